/* design/txwrl_pkg.sv */
package txwrl_pkg;

    localparam int CLIENTS      = 2;
    localparam int CLIENT_SLOTS = 2;
    localparam int BUFFER_BYTES = 2048;
    localparam int BUF_SHIFT    = $clog2(BUFFER_BYTES);

    localparam int CLIENT_W  = 1;
    localparam int OFFSET_W  = 32;
    localparam int LENGTH_W  = 16;
    localparam int WINDOW_W  = 32;
    localparam int ADDR_W    = 48;
    localparam int BUDGET_W  = 32;
    localparam int BUFFERS_W = 13;
    localparam int USED_W    = 40;
    localparam int BITS_W    = LENGTH_W + 3;
    localparam int REGION_W  = BUFFERS_W + BUF_SHIFT;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 5;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(2000000);
    localparam logic [USED_W-1:0]   USED_MAX     = '1;

    typedef enum logic [2:0] {
        ST_FORWARDED = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_HELD      = 3'd2,
        ST_RETURNED  = 3'd3,
        ST_UNOWNED   = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BUDGET0  = 3'd0,
        REG_BUDGET1  = 3'd1,
        REG_BASE0    = 3'd2,
        REG_BASE1    = 3'd3,
        REG_BUFFERS0 = 3'd4,
        REG_BUFFERS1 = 3'd5
    } cfg_reg_t;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_RETURN = 1'b1;

endpackage

/* design/tx_window_rate_limiter_unit.sv */
// Transmit descriptor gate with a fixed-window bit budget for two clients.
// Input items arrive on the s_ stream: tuser carries the operation (submit or
// return) and the client, tdata carries offset, length, window and physical
// address. Each item yields exactly one result item on the m_ stream: tuser
// carries status, owner and timer request, tdata the address and length.
// The input register and then the result register hold each item; one item is
// taken in every cycle while results are taken, as the budget check, count
// update and address translation for one item sit between the two registers.
// A submit with a new window number clears that client's used-bit count; an
// over-budget submit is held with a timer request, a bad offset is rejected,
// otherwise the offset is translated and length*8 bits are charged.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wr_data; the user must write them only while the block is idle, which
// the block itself does not enforce; indexes beyond the list are ignored.
// Reset (aresetn low, synchronous) empties both registers, restores default
// budgets, clears region bases, buffer counts, window numbers and counts.
// When m_tready is low the result holds; the input register still takes one
// more item, after which s_tready drops until the result is taken.
module tx_window_rate_limiter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // offset[31:0], length[47:32], window[79:48], phys_address[127:80]
    input  logic [txwrl_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation[0], client[1]
    input  logic [txwrl_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // address[47:0], out_length[63:48]
    output logic [txwrl_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[2:0], owner[3], timer_request[4]
    output logic [txwrl_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic [txwrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [txwrl_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int NS = txwrl_pkg::CLIENT_SLOTS;

    logic [txwrl_pkg::BUDGET_W-1:0]  budget_reg  [NS];
    logic [txwrl_pkg::ADDR_W-1:0]    base_reg    [NS];
    logic [txwrl_pkg::BUFFERS_W-1:0] buffers_reg [NS];
    logic [txwrl_pkg::WINDOW_W-1:0]  last_window_reg [NS];
    logic [txwrl_pkg::USED_W-1:0]    used_bits_reg   [NS];

    logic                                in_valid_reg;
    logic [txwrl_pkg::S_TDATA_W-1:0]     in_data_reg;
    logic [txwrl_pkg::S_TUSER_W-1:0]     in_user_reg;

    logic                                out_valid_reg;
    logic [txwrl_pkg::M_TDATA_W-1:0]     out_data_reg;
    logic [txwrl_pkg::M_TUSER_W-1:0]     out_user_reg;

    logic                                advance;
    logic                                in_op;
    logic [txwrl_pkg::CLIENT_W-1:0]      in_client;
    logic [txwrl_pkg::OFFSET_W-1:0]      in_offset;
    logic [txwrl_pkg::LENGTH_W-1:0]      in_length;
    logic [txwrl_pkg::WINDOW_W-1:0]      in_window;
    logic [txwrl_pkg::ADDR_W-1:0]        in_phys;

    logic                                client_ok;
    logic [txwrl_pkg::USED_W-1:0]        cur_used;
    logic [txwrl_pkg::USED_W:0]          used_sum;
    logic [txwrl_pkg::USED_W-1:0]        used_next;
    logic [txwrl_pkg::ADDR_W:0]          region_bytes;
    logic [txwrl_pkg::ADDR_W:0]          region_end;
    logic                                owned;
    logic [txwrl_pkg::CLIENT_W-1:0]      owner_hit;
    logic [txwrl_pkg::ADDR_W-1:0]        addr_hit;

    txwrl_pkg::status_t                  res_status;
    logic [txwrl_pkg::CLIENT_W-1:0]      res_owner;
    logic [txwrl_pkg::ADDR_W-1:0]        res_addr;
    logic [txwrl_pkg::LENGTH_W-1:0]      res_length;
    logic                                res_timer;
    logic                                upd_state;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign in_op     = in_user_reg[0];
    assign in_client = in_user_reg[1];
    assign in_offset = in_data_reg[31:0];
    assign in_length = in_data_reg[47:32];
    assign in_window = in_data_reg[79:48];
    assign in_phys   = in_data_reg[127:80];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                budget_reg[k]  <= txwrl_pkg::BUDGET_RESET;
                base_reg[k]    <= '0;
                buffers_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                txwrl_pkg::REG_BUDGET0:  budget_reg[0]  <= cfg_wr_data[txwrl_pkg::BUDGET_W-1:0];
                txwrl_pkg::REG_BUDGET1:  budget_reg[1]  <= cfg_wr_data[txwrl_pkg::BUDGET_W-1:0];
                txwrl_pkg::REG_BASE0:    base_reg[0]    <= cfg_wr_data[txwrl_pkg::ADDR_W-1:0];
                txwrl_pkg::REG_BASE1:    base_reg[1]    <= cfg_wr_data[txwrl_pkg::ADDR_W-1:0];
                txwrl_pkg::REG_BUFFERS0: buffers_reg[0] <= cfg_wr_data[txwrl_pkg::BUFFERS_W-1:0];
                txwrl_pkg::REG_BUFFERS1: buffers_reg[1] <= cfg_wr_data[txwrl_pkg::BUFFERS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        client_ok  = (32'(in_client) < txwrl_pkg::CLIENTS);
        cur_used   = (last_window_reg[in_client] != in_window) ? '0
                                                               : used_bits_reg[in_client];
        used_sum   = {1'b0, cur_used} + (txwrl_pkg::USED_W+1)'({in_length, 3'b000});
        used_next  = cur_used;
        res_status = txwrl_pkg::ST_REJECTED;
        res_owner  = in_client;
        res_addr   = txwrl_pkg::ADDR_W'(in_offset);
        res_length = in_length;
        res_timer  = 1'b0;
        upd_state  = 1'b0;
        owned      = 1'b0;
        owner_hit  = '0;
        addr_hit   = in_phys;
        region_bytes = '0;
        region_end   = '0;

        for (int k = NS - 1; k >= 0; k--) begin
            region_bytes = (txwrl_pkg::ADDR_W+1)'({buffers_reg[k],
                                                   {txwrl_pkg::BUF_SHIFT{1'b0}}});
            region_end   = {1'b0, base_reg[k]} + region_bytes;
            if (k < txwrl_pkg::CLIENTS && in_phys >= base_reg[k]
                    && {1'b0, in_phys} < region_end) begin
                owned     = 1'b1;
                owner_hit = txwrl_pkg::CLIENT_W'(k);
                addr_hit  = in_phys - base_reg[k];
            end
        end

        if (in_op == txwrl_pkg::OP_SUBMIT) begin
            region_bytes = (txwrl_pkg::ADDR_W+1)'({buffers_reg[in_client],
                                                   {txwrl_pkg::BUF_SHIFT{1'b0}}});
            if (client_ok) begin
                upd_state = 1'b1;
                if (cur_used >= txwrl_pkg::USED_W'(budget_reg[in_client])) begin
                    res_status = txwrl_pkg::ST_HELD;
                    res_timer  = 1'b1;
                end else if (in_offset[txwrl_pkg::BUF_SHIFT-1:0] == '0
                        && (txwrl_pkg::ADDR_W+1)'(in_offset) < region_bytes) begin
                    res_status = txwrl_pkg::ST_FORWARDED;
                    res_addr   = txwrl_pkg::ADDR_W'(in_offset) + base_reg[in_client];
                    used_next  = used_sum[txwrl_pkg::USED_W] ? txwrl_pkg::USED_MAX
                                                             : used_sum[txwrl_pkg::USED_W-1:0];
                end
            end
        end else begin
            res_length = '0;
            if (owned) begin
                res_status = txwrl_pkg::ST_RETURNED;
                res_owner  = owner_hit;
                res_addr   = addr_hit;
            end else begin
                res_status = txwrl_pkg::ST_UNOWNED;
                res_owner  = '0;
                res_addr   = in_phys;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                last_window_reg[k] <= '0;
                used_bits_reg[k]   <= '0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                if (upd_state) begin
                    last_window_reg[in_client] <= in_window;
                    used_bits_reg[in_client]   <= used_next;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= {res_length, res_addr};
            out_user_reg <= {res_timer, res_owner, res_status};
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input register overrun while result stalled");

    a_timer_only_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[4]) |-> (m_tuser[2:0] == txwrl_pkg::ST_HELD))
        else $error("timer request without held status");

    a_window_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && upd_state) |=> (last_window_reg[$past(in_client)] == $past(in_window)))
        else $error("window number not stored for submitting client");

    a_return_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:0] == txwrl_pkg::ST_RETURNED
                      || m_tuser[2:0] == txwrl_pkg::ST_UNOWNED))
        |-> (m_tdata[63:48] == '0))
        else $error("return result carries a length");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_tvalid && !in_valid_reg))
        else $error("registers not empty after reset");
`endif

endmodule
